// File: hdl/mcsel_pkg.sv
`timescale 1ns / 1ps

package mcsel_pkg;

    // cost and index formats
    typedef logic signed [15:0] t_cost;
    typedef logic        [7:0]  t_index;
    typedef logic        [7:0]  t_prio;

    // costs above this never qualify; also the minimum when nothing qualifies
    localparam t_cost  CAP_COST   = 16'sd255;
    // result when the minimum is over the limit
    localparam t_index NONE_INDEX = 8'hff;
    // result when no entry qualified but the limit allows it
    localparam t_index NO_ENTRY   = 8'h00;

    // register map (word index taken from paddr[2])
    localparam logic REG_COST_LIMIT = 1'b0;

endpackage

// File: hdl/min_cost_select_priority_tiebreak.sv
`timescale 1ns / 1ps

// Minimum-cost selector with priority tie-break.
// Input channel (i_in_valid / o_in_stall) carries one entry per word: a signed
// cost, a priority byte and a last flag closing the set. Entries are numbered
// from 1; only the first MAX_ENTRIES of a set compete, and only costs up to 255.
// Output channel (o_out_valid / i_out_stall) carries one word per set: the
// winning entry number, 255 when the minimum exceeds cost_limit, or 0 when
// nothing qualified but the limit allows it.
// A closing entry passes the input register, then its result is loaded into the
// result register. Throughput: one entry per cycle while o_in_stall is low;
// the compare against the running best sits between the input register
// and the best-so-far/result registers.
// The input stalls only when a closing entry waits in the input register while
// an earlier result is still held by a stalled receiver.
// cost_limit is written over the APB port at byte address 0 and reads back
// sign-extended. Reset clears the set state, the valid flags and cost_limit to 0.
module min_cost_select_priority_tiebreak #(
    parameter int MAX_ENTRIES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // entry channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_cost,
    input  logic        [7:0]   i_priority_req,
    input  logic                i_last_entry,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic        [7:0]   o_chosen_index,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic        [2:0]   paddr,
    input  logic        [31:0]  pwdata,
    output logic        [31:0]  prdata,
    output logic                pready
);

    localparam logic [7:0] MaxCnt = 8'(MAX_ENTRIES);

    // configuration
    mcsel_pkg::t_cost  r_cost_limit;

    // input register
    logic              r_in_valid;
    mcsel_pkg::t_cost  r_in_cost;
    mcsel_pkg::t_prio  r_in_prio;
    logic              r_in_last;

    // running best of the current set
    logic              r_have;
    mcsel_pkg::t_cost  r_best_cost;
    mcsel_pkg::t_prio  r_best_prio;
    mcsel_pkg::t_index r_best_idx;
    logic [7:0]        r_count;

    // result register
    logic              r_out_valid;
    mcsel_pkg::t_index r_chosen;

    logic              w_adv;
    logic              w_take;
    logic [7:0]        w_idx;
    logic              n_have;
    mcsel_pkg::t_cost  n_best_cost;
    mcsel_pkg::t_prio  n_best_prio;
    mcsel_pkg::t_index n_best_idx;
    mcsel_pkg::t_cost  w_min;
    mcsel_pkg::t_index n_chosen;
    logic              w_cfg_wr;

    // apb access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == mcsel_pkg::REG_COST_LIMIT);
    assign prdata   = (paddr[2] == mcsel_pkg::REG_COST_LIMIT)
                    ? {{16{r_cost_limit[15]}}, r_cost_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_limit <= '0;
        end else if (w_cfg_wr) begin
            r_cost_limit <= pwdata[15:0];
        end
    end

    // the held word moves on unless it closes a set and the result slot is blocked
    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    // compare against the running best
    always_comb begin
        w_idx  = r_count + 8'd1;
        w_take = (r_count < MaxCnt) && (r_in_cost <= mcsel_pkg::CAP_COST)
              && (!r_have || (r_in_cost < r_best_cost)
                  || ((r_in_cost == r_best_cost) && (r_in_prio > r_best_prio)));
        n_have      = r_have || w_take;
        n_best_cost = w_take ? r_in_cost : r_best_cost;
        n_best_prio = w_take ? r_in_prio : r_best_prio;
        n_best_idx  = w_take ? w_idx     : r_best_idx;
        w_min       = n_have ? n_best_cost : mcsel_pkg::CAP_COST;
        if (w_min > r_cost_limit) begin
            n_chosen = mcsel_pkg::NONE_INDEX;
        end else begin
            n_chosen = n_have ? n_best_idx : mcsel_pkg::NO_ENTRY;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cost <= i_cost;
            r_in_prio <= i_priority_req;
            r_in_last <= i_last_entry;
        end
    end

    // set state: update per entry, clear after the closing entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_cost <= mcsel_pkg::CAP_COST;
            r_best_prio <= '0;
            r_best_idx  <= '0;
            r_count     <= '0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_have      <= 1'b0;
                r_best_cost <= mcsel_pkg::CAP_COST;
                r_best_prio <= '0;
                r_best_idx  <= '0;
                r_count     <= '0;
            end else begin
                r_have      <= n_have;
                r_best_cost <= n_best_cost;
                r_best_prio <= n_best_prio;
                r_best_idx  <= n_best_idx;
                if (r_count < MaxCnt) begin
                    r_count <= w_idx;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_chosen <= n_chosen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_chosen;

`ifndef SYNTHESIS
    // a new result only follows a closing entry leaving the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_last))
        else $error("result appeared without a closing entry");

    // input stalls only behind a blocked result slot
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

    // set state is cleared once a set closes
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (!r_have && (r_count == 8'd0)))
        else $error("set state not cleared after closing entry");

    // a held candidate always has a legal entry number
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> ((r_best_idx != 8'd0) && (r_best_idx <= MaxCnt) && (r_best_idx <= r_count)))
        else $error("candidate index out of range");
`endif

endmodule
